// ----- rtl/core/rhc_pkg.sv -----
// Shared command codes for the reference-counted handle cache.
package rhc_pkg;

	typedef enum logic [1:0] {
		CMD_RETAIN   = 2'd0,
		CMD_RELEASE  = 2'd1,
		CMD_CONTAINS = 2'd2,
		CMD_DRAIN    = 2'd3
	} cmd_t;

endpackage

// ----- rtl/core/rhc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rhc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/refcounted_handle_cache_top.sv -----
// Reference-counted handle table keyed by surface, with sequential lookup and compaction.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------------
//   in      | to block  | in_valid/in_stall  | cmd, surface_key, filter_sel, handle_in
//   out     | from blk  | out_valid/out_stall| handle_out, match_flag, needs_upload,
//           |           |                    | status, last
//
// Retain, release, contains: entries are scanned in order through the single RAM read port
// by the shared key comparator until the key matches; when an entry is removed, the entries
// behind it move down one place. A result is held while out_stall is high.
// Drain: each used entry is read and its live handles are returned; the table ends empty.
// Reset empties the table at once (fill count cleared); no clearing pass.
// in_stall is high from acceptance until the last result of the request is taken.
module refcounted_handle_cache_top
	import rhc_pkg::*;
#(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] surface_key,
	input  logic        filter_sel,
	input  logic [31:0] handle_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] handle_out,
	output logic        match_flag,
	output logic        needs_upload,
	output logic        status,
	output logic        last
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);

	typedef struct packed {
		logic [31:0]           key;
		logic [31:0]           h1;
		logic [COUNT_BITS-1:0] c1;
		logic [31:0]           h0;
		logic [COUNT_BITS-1:0] c0;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK_RD,
		ST_LOOK_CMP,
		ST_EXEC,
		ST_COMP_RD,
		ST_COMP_WR,
		ST_DR_RD,
		ST_DR_LATCH,
		ST_DR_SLOT,
		ST_DR_NEXT,
		ST_DR_DONE,
		ST_EMIT
	} state_t;

	state_t                state_q, ret_q;
	cmd_t                  cmd_q;
	logic [31:0]           key_q, hin_q;
	logic                  flt_q;
	logic [CNT_W-1:0]      idx_q, used_q;
	logic [IDX_W-1:0]      ent_q;
	logic                  found_q, sub_q, pend_v_q;
	logic [31:0]           pend_h_q;
	row_t                  row_q;
	logic [31:0]           handle_q;
	logic                  match_q, upload_q, status_q, last_q;

	logic [CNT_W-1:0]      idx_nx;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr, ram_raddr;
	logic [ROW_W-1:0]      ram_wdata, ram_rdata;
	row_t                  rd_row;

	logic [31:0]           sel_h, oth_h, dr_h;
	logic [COUNT_BITS-1:0] sel_c, wr_c;
	logic [31:0]           wr_h;
	row_t                  base_row, ex_row;
	logic                  ex_we, ex_set, ex_m, ex_u, ex_s, ex_grow, ex_compact;
	logic [IDX_W-1:0]      ex_addr;
	logic [31:0]           ex_h;

	assign idx_nx = idx_q + CNT_W'(1);
	assign rd_row = row_t'(ram_rdata);
	assign dr_h   = sub_q ? row_q.h1 : row_q.h0;

	always_comb begin
		sel_h      = flt_q ? row_q.h1 : row_q.h0;
		sel_c      = flt_q ? row_q.c1 : row_q.c0;
		oth_h      = flt_q ? row_q.h0 : row_q.h1;
		base_row   = row_q;
		wr_h       = sel_h;
		wr_c       = sel_c;
		ex_we      = 1'b0;
		ex_set     = 1'b0;
		ex_addr    = ent_q;
		ex_h       = '0;
		ex_m       = 1'b0;
		ex_u       = 1'b0;
		ex_s       = 1'b0;
		ex_grow    = 1'b0;
		ex_compact = 1'b0;
		unique case (cmd_q)
			CMD_RETAIN: begin
				if (found_q && sel_h != '0) begin
					ex_we  = 1'b1;
					ex_set = 1'b1;
					wr_c   = (sel_c == COUNT_MAX) ? sel_c : sel_c + COUNT_BITS'(1);
					ex_h   = sel_h;
				end else if (hin_q == '0) begin
					ex_h = '0;
				end else if (!found_q) begin
					if (used_q == ENTRIES_C) begin
						ex_s = 1'b1;
					end else begin
						base_row = '{key: key_q, h1: '0, c1: '0, h0: '0, c0: '0};
						ex_we    = 1'b1;
						ex_set   = 1'b1;
						ex_addr  = used_q[IDX_W-1:0];
						ex_grow  = 1'b1;
						wr_h     = hin_q;
						wr_c     = COUNT_BITS'(1);
						ex_h     = hin_q;
						ex_u     = 1'b1;
					end
				end else begin
					ex_we  = 1'b1;
					ex_set = 1'b1;
					wr_h   = hin_q;
					wr_c   = COUNT_BITS'(1);
					ex_h   = hin_q;
					ex_u   = 1'b1;
				end
			end
			CMD_RELEASE: begin
				if (found_q && sel_h == hin_q) begin
					ex_set = 1'b1;
					wr_c   = (sel_c != '0) ? sel_c - COUNT_BITS'(1) : '0;
					if (wr_c != '0) begin
						ex_we = 1'b1;
					end else begin
						wr_h = '0;
						ex_h = sel_h;
						if (oth_h == '0) begin
							ex_compact = 1'b1;
						end else begin
							ex_we = 1'b1;
						end
					end
				end
			end
			CMD_CONTAINS: begin
				ex_m = found_q && (sel_h == hin_q);
			end
			CMD_DRAIN: begin
				ex_h = '0;
			end
			default: begin
				ex_h = '0;
			end
		endcase
		ex_row = base_row;
		if (ex_set) begin
			if (flt_q) begin
				ex_row.h1 = wr_h;
				ex_row.c1 = wr_c;
			end else begin
				ex_row.h0 = wr_h;
				ex_row.c0 = wr_c;
			end
		end
	end

	always_comb begin
		ram_raddr = idx_q[IDX_W-1:0];
		if (state_q == ST_COMP_RD || state_q == ST_COMP_WR) begin
			ram_raddr = idx_nx[IDX_W-1:0];
		end
		ram_we    = (state_q == ST_EXEC && ex_we) || state_q == ST_COMP_WR;
		ram_waddr = (state_q == ST_COMP_WR) ? idx_q[IDX_W-1:0] : ex_addr;
		ram_wdata = (state_q == ST_COMP_WR) ? ram_rdata : ROW_W'(ex_row);
	end

	rhc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			cmd_q    <= CMD_RETAIN;
			key_q    <= '0;
			hin_q    <= '0;
			flt_q    <= 1'b0;
			idx_q    <= '0;
			used_q   <= '0;
			ent_q    <= '0;
			found_q  <= 1'b0;
			sub_q    <= 1'b0;
			pend_v_q <= 1'b0;
			pend_h_q <= '0;
			row_q    <= '0;
			handle_q <= '0;
			match_q  <= 1'b0;
			upload_q <= 1'b0;
			status_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q    <= cmd_t'(cmd);
						key_q    <= surface_key;
						flt_q    <= filter_sel;
						hin_q    <= handle_in;
						idx_q    <= '0;
						found_q  <= 1'b0;
						pend_v_q <= 1'b0;
						if (cmd_t'(cmd) == CMD_DRAIN) begin
							state_q <= (used_q == '0) ? ST_DR_DONE : ST_DR_RD;
						end else begin
							state_q <= (used_q == '0) ? ST_EXEC : ST_LOOK_RD;
						end
					end
				end
				ST_LOOK_RD: begin
					state_q <= ST_LOOK_CMP;
				end
				ST_LOOK_CMP: begin
					if (rd_row.key == key_q) begin
						found_q <= 1'b1;
						row_q   <= rd_row;
						ent_q   <= idx_q[IDX_W-1:0];
						state_q <= ST_EXEC;
					end else if (idx_nx == used_q) begin
						state_q <= ST_EXEC;
					end else begin
						idx_q   <= idx_nx;
						state_q <= ST_LOOK_RD;
					end
				end
				ST_EXEC: begin
					handle_q <= ex_h;
					match_q  <= ex_m;
					upload_q <= ex_u;
					status_q <= ex_s;
					last_q   <= 1'b1;
					ret_q    <= ST_IDLE;
					if (ex_grow) begin
						used_q <= used_q + CNT_W'(1);
					end
					if (ex_compact) begin
						idx_q   <= CNT_W'(ent_q);
						state_q <= ST_COMP_RD;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_COMP_RD: begin
					if (idx_nx >= used_q) begin
						used_q  <= used_q - CNT_W'(1);
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_COMP_WR;
					end
				end
				ST_COMP_WR: begin
					idx_q   <= idx_nx;
					state_q <= ST_COMP_RD;
				end
				ST_DR_RD: begin
					state_q <= ST_DR_LATCH;
				end
				ST_DR_LATCH: begin
					row_q   <= rd_row;
					sub_q   <= 1'b1;
					state_q <= ST_DR_SLOT;
				end
				ST_DR_SLOT: begin
					if (dr_h != '0) begin
						pend_v_q <= 1'b1;
						pend_h_q <= dr_h;
					end
					if (dr_h != '0 && pend_v_q) begin
						handle_q <= pend_h_q;
						match_q  <= 1'b0;
						upload_q <= 1'b0;
						status_q <= 1'b0;
						last_q   <= 1'b0;
						ret_q    <= ST_DR_NEXT;
						state_q  <= ST_EMIT;
					end else begin
						state_q <= ST_DR_NEXT;
					end
				end
				ST_DR_NEXT: begin
					if (sub_q) begin
						sub_q   <= 1'b0;
						state_q <= ST_DR_SLOT;
					end else if (idx_nx == used_q) begin
						state_q <= ST_DR_DONE;
					end else begin
						idx_q   <= idx_nx;
						state_q <= ST_DR_RD;
					end
				end
				ST_DR_DONE: begin
					handle_q <= pend_v_q ? pend_h_q : '0;
					match_q  <= 1'b0;
					upload_q <= 1'b0;
					status_q <= 1'b0;
					last_q   <= 1'b1;
					pend_v_q <= 1'b0;
					used_q   <= '0;
					ret_q    <= ST_IDLE;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_stall) begin
						state_q <= ret_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = (state_q == ST_EMIT);
	assign handle_out   = handle_q;
	assign match_flag   = match_q;
	assign needs_upload = upload_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule

// ----- rtl/core/rhc_checker.sv -----
// Port-level checks for the handle cache and their binding to the top level.
module rhc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] handle_out,
	input logic        match_flag,
	input logic        needs_upload,
	input logic        status,
	input logic        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(handle_out) && $stable(last))
		else $error("stalled result changed");

	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while a result waits");

	a_match_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && match_flag |-> last && handle_out == 32'd0 && !needs_upload && !status)
		else $error("match result carries other fields");

	a_upload_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && needs_upload |-> handle_out != 32'd0 && !status && last)
		else $error("upload flagged without a handle");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> handle_out == 32'd0 && last)
		else $error("full status with a handle");

endmodule

bind refcounted_handle_cache_top rhc_checker u_rhc_checker (.*);

// ----- bench/tb_refcounted_handle_cache_top.sv -----
// Self-checking testbench for the reference-counted handle cache: directed and random requests.
`timescale 1ns / 1ps

class handle_cache_shadow #(int N = 16, int CW = 16);
	typedef struct {
		logic [31:0] handle;
		logic        match;
		logic        upload;
		logic        full;
		logic        tail;
	} cache_result_t;

	logic [31:0]   keys [N];
	logic [31:0]   handles [2*N];
	logic [CW-1:0] counts [2*N];
	int            used;
	cache_result_t due_results [$];
	int            errors;

	function new();
		errors = 0;
		clear();
	endfunction

	function void clear();
		for (int i = 0; i < N; i++) keys[i] = '0;
		for (int i = 0; i < 2*N; i++) begin
			handles[i] = '0;
			counts[i] = '0;
		end
		used = 0;
	endfunction

	function int find(logic [31:0] key);
		for (int i = 0; i < used; i++)
			if (keys[i] == key) return i;
		return -1;
	endfunction

	function void drop_entry(int e);
		for (int i = e; i + 1 < used; i++) begin
			keys[i] = keys[i+1];
			handles[2*i] = handles[2*i+2];
			handles[2*i+1] = handles[2*i+3];
			counts[2*i] = counts[2*i+2];
			counts[2*i+1] = counts[2*i+3];
		end
		if (used > 0) begin
			used--;
			keys[used] = '0;
			handles[2*used] = '0;
			handles[2*used+1] = '0;
			counts[2*used] = '0;
			counts[2*used+1] = '0;
		end
	endfunction

	function void due(logic [31:0] h, logic m, logic u, logic s, logic l);
		cache_result_t r;
		r.handle = h;
		r.match = m;
		r.upload = u;
		r.full = s;
		r.tail = l;
		due_results.push_back(r);
	endfunction

	function void apply_request(rhc_pkg::cmd_t c, logic [31:0] key, logic f, logic [31:0] h);
		int e;
		int s;
		int n;
		logic [31:0] rel;
		logic m;
		e = find(key);
		case (c)
		rhc_pkg::CMD_RETAIN: begin
			if (e >= 0 && handles[2*e + int'(f)] != '0) begin
				s = 2*e + int'(f);
				if (counts[s] != '1) counts[s]++;
				due(handles[s], 1'b0, 1'b0, 1'b0, 1'b1);
			end else if (h == '0) begin
				due('0, 1'b0, 1'b0, 1'b0, 1'b1);
			end else if (e < 0 && used >= N) begin
				due('0, 1'b0, 1'b0, 1'b1, 1'b1);
			end else begin
				if (e < 0) begin
					e = used;
					keys[e] = key;
					handles[2*e] = '0;
					handles[2*e+1] = '0;
					counts[2*e] = '0;
					counts[2*e+1] = '0;
					used++;
				end
				s = 2*e + int'(f);
				handles[s] = h;
				counts[s] = CW'(1);
				due(h, 1'b0, 1'b1, 1'b0, 1'b1);
			end
		end
		rhc_pkg::CMD_RELEASE: begin
			rel = '0;
			if (e >= 0) begin
				s = 2*e + int'(f);
				if (handles[s] == h) begin
					if (counts[s] != '0) counts[s]--;
					if (counts[s] == '0) begin
						rel = handles[s];
						handles[s] = '0;
						if (handles[2*e] == '0 && handles[2*e+1] == '0) drop_entry(e);
					end
				end
			end
			due(rel, 1'b0, 1'b0, 1'b0, 1'b1);
		end
		rhc_pkg::CMD_CONTAINS: begin
			m = 1'b0;
			if (e >= 0) m = (handles[2*e + int'(f)] == h);
			due('0, m, 1'b0, 1'b0, 1'b1);
		end
		default: begin
			n = 0;
			for (int i = 0; i < used; i++) begin
				if (handles[2*i+1] != '0) begin
					due(handles[2*i+1], 1'b0, 1'b0, 1'b0, 1'b0);
					n++;
				end
				if (handles[2*i] != '0) begin
					due(handles[2*i], 1'b0, 1'b0, 1'b0, 1'b0);
					n++;
				end
			end
			if (n == 0) due('0, 1'b0, 1'b0, 1'b0, 1'b1);
			else due_results[due_results.size()-1].tail = 1'b1;
			clear();
		end
		endcase
	endfunction

	task report(string msg);
		if (errors < 100) $display("MISMATCH: %s", msg);
		errors++;
	endtask

	task check_result(logic [31:0] h, logic m, logic u, logic s, logic l);
		cache_result_t want;
		if (due_results.size() == 0) begin
			report($sformatf("result with no request pending, handle_out %h", h));
			return;
		end
		want = due_results.pop_front();
		if (h !== want.handle)
			report($sformatf("handle_out got %h want %h", h, want.handle));
		if (m !== want.match)
			report($sformatf("match_flag got %b want %b", m, want.match));
		if (u !== want.upload)
			report($sformatf("needs_upload got %b want %b", u, want.upload));
		if (s !== want.full)
			report($sformatf("status got %b want %b", s, want.full));
		if (l !== want.tail)
			report($sformatf("last got %b want %b", l, want.tail));
	endtask
endclass

module tb_refcounted_handle_cache_top;
	import rhc_pkg::*;

	localparam int ENTRIES = 16;
	localparam int COUNT_BITS = 16;
	localparam int PHASE_ITEMS = 108;
	localparam int POOL_SIZE = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 200;
	localparam int REPEAT_RETAINS = 8;
	localparam int CYCLE_LIMIT = 4000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	cmd_t        cmd = CMD_RETAIN;
	logic [31:0] surface_key = '0;
	logic        filter_sel = 1'b0;
	logic [31:0] handle_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] handle_out;
	logic        match_flag;
	logic        needs_upload;
	logic        status;
	logic        last;

	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	logic        hold_go = 1'b0;
	logic        hold_on = 1'b0;
	logic [31:0] key_pool [POOL_SIZE];

	handle_cache_shadow #(ENTRIES, COUNT_BITS) shadow;

	refcounted_handle_cache_top #(
		.ENTRIES(ENTRIES),
		.COUNT_BITS(COUNT_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.surface_key(surface_key),
		.filter_sel(filter_sel),
		.handle_in(handle_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.handle_out(handle_out),
		.match_flag(match_flag),
		.needs_upload(needs_upload),
		.status(status),
		.last(last)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		if (hold_on) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			shadow.check_result(handle_out, match_flag, needs_upload, status, last);
	end

	initial begin : holdoff
		wait (hold_go);
		@(posedge clk);
		hold_on = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on = 1'b0;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_refcounted_handle_cache_top: done, errors");
		$finish;
	end

	task automatic send_request(cmd_t c, logic [31:0] key, logic f, logic [31:0] h);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		surface_key <= key;
		filter_sel <= f;
		handle_in <= h;
		do @(posedge clk); while (in_stall);
		shadow.apply_request(c, key, f, h);
	endtask

	task automatic send_random();
		int pick;
		int e;
		logic [31:0] key;
		logic f;
		logic [31:0] h;
		cmd_t c;
		pick = $urandom_range(99);
		if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE-1)];
		else key = $urandom();
		f = 1'($urandom_range(1));
		e = shadow.find(key);
		if (pick < 45) c = CMD_RETAIN;
		else if (pick < 75) c = CMD_RELEASE;
		else if (pick < 97) c = CMD_CONTAINS;
		else c = CMD_DRAIN;
		h = $urandom();
		if (c == CMD_RETAIN) begin
			if ($urandom_range(99) < 5) h = '0;
		end else begin
			pick = $urandom_range(99);
			if (pick < 70 && e >= 0) h = shadow.handles[2*e + int'(f)];
			else if (pick < 80) h = '0;
		end
		send_request(c, key, f, h);
	endtask

	initial begin
		shadow = new();
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 8;
		rx_idle_pct = 47;

		send_request(CMD_DRAIN, 32'h0, 1'b0, 32'h0);
		send_request(CMD_CONTAINS, 32'h0, 1'b0, 32'h0);
		send_request(CMD_RELEASE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_request(CMD_RETAIN, 32'h0, 1'b0, 32'hFFFF_FFFF);
		send_request(CMD_RETAIN, 32'h0, 1'b0, 32'h0000_0005);
		send_request(CMD_RETAIN, 32'hFFFF_FFFF, 1'b1, 32'h0);
		send_request(CMD_CONTAINS, 32'h0, 1'b1, 32'h0);
		send_request(CMD_RELEASE, 32'h0, 1'b1, 32'h0);
		send_request(CMD_RELEASE, 32'h0, 1'b0, 32'h0000_1234);
		for (int i = 1; i < ENTRIES; i++)
			send_request(CMD_RETAIN, 32'h0100_0000 + i, i[0], $urandom() | 32'h1);
		send_request(CMD_RETAIN, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000);
		send_request(CMD_RELEASE, 32'h0, 1'b0, 32'hFFFF_FFFF);
		send_request(CMD_RELEASE, 32'h0, 1'b0, 32'hFFFF_FFFF);
		send_request(CMD_DRAIN, 32'h0, 1'b0, 32'h0);

		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i == 30) hold_go = 1'b1;
			send_random();
		end

		tx_idle_pct = 47;
		rx_idle_pct = 8;
		for (int i = 0; i < PHASE_ITEMS; i++) send_random();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_request(CMD_DRAIN, 32'h0, 1'b0, 32'h0);
		repeat (REPEAT_RETAINS) send_request(CMD_RETAIN, 32'h5A5A_0001, 1'b1, 32'h0000_0001);
		send_request(CMD_RELEASE, 32'h5A5A_0001, 1'b1, 32'h0000_0001);
		send_request(CMD_CONTAINS, 32'h5A5A_0001, 1'b1, 32'h0000_0001);
		for (int i = 0; i < PHASE_ITEMS; i++) send_random();
		send_request(CMD_DRAIN, 32'h0, 1'b0, 32'h0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (shadow.due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (shadow.errors == 0 && shadow.due_results.size() == 0)
			$display("tb_refcounted_handle_cache_top: done, clean");
		else
			$display("tb_refcounted_handle_cache_top: done, errors");
		$finish;
	end

endmodule
